@@ rtl/hmp_pkg.sv @@
// Shared constants and the controller-to-datapath command type for the
// harmonic magnitude to polynomial converter. No dependencies.
package hmp_pkg;

    localparam int NUM_TERMS_DEF = 11;
    localparam int HARM_W        = 4;
    localparam int MAG_W         = 16;
    localparam int COEF_W        = 32;
    localparam int POW_W         = 4;
    localparam int ACC_W         = 64;
    localparam int SUM_W         = 20;
    localparam int QUO_W         = SUM_W + 1;
    localparam int CW_W          = 22;
    localparam int NUM_W         = 36;
    localparam int FRAC_BITS     = 20;
    localparam int SMALL_SHIFT   = 6;
    localparam int ONE_Q14       = 16384;
    localparam int DIV_STEPS     = NUM_W;

    typedef struct packed {
        logic sum_clr;
        logic sum_acc;
        logic scale_load;
        logic div_step;
        logic c_write;
        logic rec_init;
        logic rec_step;
        logic rec_final;
    } dp_cmd_t;

endpackage

@@ rtl/hmp_in_if.sv @@
// Input channel: harmonic magnitude beats, valid/ready handshake.
// Depends on hmp_pkg.
interface hmp_in_if;
    logic                          valid;
    logic                          ready;
    logic [hmp_pkg::HARM_W-1:0]    harmonic_number;
    logic signed [hmp_pkg::MAG_W-1:0] magnitude;
    logic                          last;

    modport source (output valid, harmonic_number, magnitude, last, input ready);
    modport sink   (input valid, harmonic_number, magnitude, last, output ready);
endinterface

@@ rtl/hmp_out_if.sv @@
// Output channel: power-series coefficient beats, valid/ready handshake.
// Depends on hmp_pkg.
interface hmp_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [hmp_pkg::COEF_W-1:0] coefficient;
    logic [hmp_pkg::POW_W-1:0]        power;
    logic                             final_res;

    modport source (output valid, coefficient, power, final_res, input ready);
    modport sink   (input valid, coefficient, power, final_res, output ready);
endinterface

@@ rtl/harmonic_magnitudes_to_polynomial.sv @@
// Top level of the harmonic magnitude to polynomial converter.
// Depends on hmp_pkg, hmp_in_if, hmp_out_if, hmp_controller, hmp_datapath.
//
// Usage:
//   harm: one beat per harmonic magnitude (harmonic_number 1..NUM_TERMS-1,
//   signed Q2.14). Out-of-range harmonic numbers are not stored. A beat with
//   last set is stored, then starts the conversion.
//   coef: NUM_TERMS beats of signed Q12.20 coefficients, power 0 first,
//   final_res on the highest power, saturated to 32 bits.
// Sequence:
//   After a last beat the block sums the absolute magnitudes, then per
//   harmonic writes the weight directly when the sum is below one, else
//   runs the bit-serial divider, then runs the recurrence before the first
//   coefficient appears. Coefficients then leave one per cycle while the
//   receiver is ready.
// Reset clears the magnitude store and returns to accepting beats.
// While the receiver stalls, the current coefficient holds and harm is
// not ready until the last coefficient is taken.
module harmonic_magnitudes_to_polynomial #(
    parameter int NUM_TERMS = hmp_pkg::NUM_TERMS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hmp_in_if.sink     harm,
    hmp_out_if.source  coef
);
    import hmp_pkg::*;

    localparam int IW = $clog2(NUM_TERMS);

    dp_cmd_t       cmd;
    logic [IW-1:0] idx;
    logic          scale_small;

    hmp_controller #(
        .NUM_TERMS (NUM_TERMS),
        .IW        (IW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (harm.valid),
        .in_last     (harm.last),
        .in_ready    (harm.ready),
        .out_valid   (coef.valid),
        .out_ready   (coef.ready),
        .scale_small (scale_small),
        .cmd         (cmd),
        .idx         (idx)
    );

    hmp_datapath #(
        .NUM_TERMS (NUM_TERMS),
        .IW        (IW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_fire         (harm.valid && harm.ready),
        .harmonic_number (harm.harmonic_number),
        .magnitude       (harm.magnitude),
        .cmd             (cmd),
        .idx             (idx),
        .scale_small     (scale_small),
        .coefficient     (coef.coefficient)
    );

    assign coef.power     = POW_W'(idx);
    assign coef.final_res = idx == IW'(NUM_TERMS - 1);

endmodule

@@ rtl/hmp_datapath.sv @@
// Datapath: magnitude store, abs sum, serial divider, scaled weights and
// the Chebyshev-to-power recurrence lanes. Depends on hmp_pkg.
module hmp_datapath #(
    parameter int NUM_TERMS = hmp_pkg::NUM_TERMS_DEF,
    parameter int IW        = $clog2(NUM_TERMS)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_fire,
    input  logic [hmp_pkg::HARM_W-1:0]         harmonic_number,
    input  logic signed [hmp_pkg::MAG_W-1:0]   magnitude,
    input  hmp_pkg::dp_cmd_t                   cmd,
    input  logic [IW-1:0]                      idx,
    output logic                               scale_small,
    output logic signed [hmp_pkg::COEF_W-1:0]  coefficient
);
    import hmp_pkg::*;

    logic signed [MAG_W-1:0] store_reg [NUM_TERMS];
    logic [SUM_W-1:0]        sum_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic                    neg_reg;
    logic signed [CW_W-1:0]  c_reg [NUM_TERMS];
    logic signed [ACC_W-1:0] work_reg [NUM_TERMS];
    logic signed [ACC_W-1:0] prev_reg [NUM_TERMS];

    logic signed [MAG_W-1:0] mag_sel;
    logic [MAG_W:0]          mag_abs;
    logic [SUM_W:0]          rem_shift;
    logic                    rem_ge;
    logic signed [CW_W-1:0]  c_small;
    logic signed [CW_W-1:0]  c_div;
    logic signed [ACC_W-1:0] out_sel;

    // Select and rectify the store entry under the shared index
    always_comb
    begin
        mag_sel     = store_reg[idx];
        mag_abs     = mag_sel[MAG_W-1] ? (MAG_W+1)'(-$signed({mag_sel[MAG_W-1], mag_sel}))
                                       : (MAG_W+1)'({1'b0, mag_sel});
        scale_small = sum_reg < SUM_W'(ONE_Q14);
        rem_shift   = {rem_reg, num_reg[NUM_W-1]};
        rem_ge      = rem_shift >= {1'b0, sum_reg};
        c_small     = CW_W'(mag_sel) <<< SMALL_SHIFT;
        c_div       = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    end

    // Store magnitudes, entry zero stays zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TERMS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (in_fire && harmonic_number != '0
                 && {1'b0, harmonic_number} < (HARM_W+1)'(NUM_TERMS))
        begin
            store_reg[harmonic_number[IW-1:0]] <= magnitude;
        end
    end

    // Abs sum and restoring divider, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_acc)
        begin
            sum_reg <= sum_reg + SUM_W'(mag_abs);
        end

        if (cmd.scale_load)
        begin
            num_reg <= (NUM_W'(mag_abs) << FRAC_BITS) + NUM_W'(sum_reg >> 1);
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= mag_sel[MAG_W-1];
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_ge ? SUM_W'(rem_shift - {1'b0, sum_reg}) : SUM_W'(rem_shift);
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
        end

        // Write the scaled weight: direct when the sum is below one
        if (cmd.scale_load && scale_small)
        begin
            c_reg[idx] <= c_small;
        end
        else if (cmd.c_write)
        begin
            c_reg[idx] <= c_div;
        end
    end

    // Recurrence lanes, all active lanes update in the same cycle
    always_ff @(posedge clk)
    begin
        if (cmd.rec_init)
        begin
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                prev_reg[k] <= '0;
            end
            for (int k = 1; k < NUM_TERMS; k++)
            begin
                work_reg[k] <= '0;
            end
            work_reg[0] <= ACC_W'(c_reg[NUM_TERMS-1]);
        end
        else if (cmd.rec_step)
        begin
            for (int k = 1; k < NUM_TERMS; k++)
            begin
                if ((IW+1)'(k) + {1'b0, idx} <= (IW+1)'(NUM_TERMS))
                begin
                    work_reg[k] <= (work_reg[k-1] <<< 1) - prev_reg[k];
                    prev_reg[k] <= work_reg[k];
                end
            end
            work_reg[0] <= ACC_W'(c_reg[idx]) - prev_reg[0];
            prev_reg[0] <= work_reg[0];
        end
        else if (cmd.rec_final)
        begin
            for (int k = 1; k < NUM_TERMS; k++)
            begin
                work_reg[k] <= work_reg[k-1] - prev_reg[k];
            end
            work_reg[0] <= -prev_reg[0];
        end
    end

    // Saturate the selected coefficient to 32 bits
    always_comb
    begin
        out_sel = work_reg[idx];
        if (out_sel > $signed(ACC_W'({1'b0, {(COEF_W-1){1'b1}}})))
        begin
            coefficient = {1'b0, {(COEF_W-1){1'b1}}};
        end
        else if (out_sel < -(ACC_W'(1) <<< (COEF_W-1)))
        begin
            coefficient = {1'b1, {(COEF_W-1){1'b0}}};
        end
        else
        begin
            coefficient = out_sel[COEF_W-1:0];
        end
    end

endmodule

@@ rtl/hmp_controller.sv @@
// Sequencer: load, sum, scale, recurrence and emit phases.
// Depends on hmp_pkg.
module hmp_controller #(
    parameter int NUM_TERMS = hmp_pkg::NUM_TERMS_DEF,
    parameter int IW        = $clog2(NUM_TERMS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  logic             scale_small,
    output hmp_pkg::dp_cmd_t cmd,
    output logic [IW-1:0]    idx
);
    import hmp_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SUM   = 9'b000000010,
        S_SCALE = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_CWR   = 9'b000010000,
        S_INIT  = 9'b000100000,
        S_REC   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    localparam logic [IW-1:0] IDX_TOP = IW'(NUM_TERMS - 1);
    localparam int            BW      = $clog2(DIV_STEPS);

    state_t          state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [BW-1:0]   bit_reg, bit_next;
    logic            in_fire;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign in_fire   = in_valid && in_ready;
    assign idx       = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_last)
                begin
                    cmd.sum_clr = 1'b1;
                    idx_next    = '0;
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_acc = 1'b1;
                if (idx_reg == IDX_TOP)
                begin
                    idx_next   = IW'(1);
                    state_next = S_SCALE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCALE:
            begin
                cmd.scale_load = 1'b1;
                bit_next       = '0;
                if (!scale_small)
                begin
                    state_next = S_DIV;
                end
                else if (idx_reg == IDX_TOP)
                begin
                    state_next = S_INIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + 1'b1;
                if (bit_reg == BW'(DIV_STEPS - 1))
                begin
                    state_next = S_CWR;
                end
            end
            S_CWR:
            begin
                cmd.c_write = 1'b1;
                if (idx_reg == IDX_TOP)
                begin
                    state_next = S_INIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCALE;
                end
            end
            S_INIT:
            begin
                cmd.rec_init = 1'b1;
                idx_next     = IW'(NUM_TERMS - 2);
                state_next   = S_REC;
            end
            S_REC:
            begin
                cmd.rec_step = 1'b1;
                if (idx_reg == IW'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_FIN:
            begin
                cmd.rec_final = 1'b1;
                idx_next      = '0;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == IDX_TOP)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bit_reg   <= bit_next;
        end
    end

endmodule
